>>> rtl/cft_pkg.sv
package cft_pkg;

   localparam int LINE_MAX   = 4096;
   localparam int FIELD_MAX  = 1024;
   localparam int MAX_FIELDS = 256;

   localparam int LINE_LEN_W  = $clog2(LINE_MAX + 1);
   localparam int FIELD_LEN_W = $clog2(FIELD_MAX + 1);
   localparam int FIELD_CAP   = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

   localparam logic [15:0] UNIT_LF    = 16'h000A;
   localparam logic [15:0] UNIT_CR    = 16'h000D;
   localparam logic [15:0] UNIT_COMMA = 16'h002C;
   localparam logic [15:0] UNIT_QUOTE = 16'h0022;

   localparam logic [15:0] HEADER_RESET = 16'd2;
   localparam logic [15:0] LINE_COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      EV_UNIT       = 2'd0,
      EV_FIELD_END  = 2'd1,
      EV_LINE_FIELD = 2'd2,
      EV_LINE_EMPTY = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      QC_NONE = 2'd0,
      QC_ODD  = 2'd1,
      QC_EVEN = 2'd2
   } quote_count_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [15:0]    kept_unit;
      logic [7:0]     field_number;
      logic [15:0]    line_number;
      logic           is_header;
      logic           truncated;
   } result_type;

endpackage

>>> rtl/cft_parser.sv
module cft_parser
   import cft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [15:0] code_unit,
   input  logic        end_of_input,
   input  logic [15:0] header_line_number,
   output logic        has_result,
   output result_type  result
);

   logic [LINE_LEN_W-1:0]  line_length_ff, line_length_in;
   logic [15:0]            line_count_ff, line_count_in;
   logic [FIELD_LEN_W-1:0] field_length_ff, field_length_in;
   logic [7:0]             field_index_ff, field_index_in;
   logic                   quoted_field_ff, quoted_field_in;
   quote_count_type        quote_count_ff, quote_count_in;
   logic                   prev_quote_ff, prev_quote_in;
   logic                   overflow_ff, overflow_in;

   always_comb begin
      logic is_quote;
      logic do_keep;
      logic do_end;
      is_quote        = (code_unit == UNIT_QUOTE);
      do_keep         = 1'b0;
      do_end          = 1'b0;
      line_length_in  = line_length_ff;
      line_count_in   = line_count_ff;
      field_length_in = field_length_ff;
      field_index_in  = field_index_ff;
      quoted_field_in = quoted_field_ff;
      quote_count_in  = quote_count_ff;
      prev_quote_in   = prev_quote_ff;
      overflow_in     = overflow_ff;
      has_result      = 1'b0;
      result.event_kind   = EV_UNIT;
      result.kept_unit    = '0;
      result.field_number = field_index_ff;
      result.line_number  = line_count_ff;
      result.is_header    = (line_count_ff == header_line_number);
      result.truncated    = overflow_ff;

      if (end_of_input || code_unit == UNIT_LF || code_unit == UNIT_CR) begin
         if (line_length_ff != '0 && line_count_ff >= header_line_number) begin
            has_result        = 1'b1;
            result.event_kind = (field_length_ff != '0) ? EV_LINE_FIELD : EV_LINE_EMPTY;
         end
         line_length_in  = '0;
         field_length_in = '0;
         field_index_in  = '0;
         quoted_field_in = 1'b0;
         quote_count_in  = QC_NONE;
         prev_quote_in   = 1'b0;
         overflow_in     = 1'b0;
         if (end_of_input) begin
            line_count_in = '0;
         end
      end else if (line_length_ff >= LINE_LEN_W'(LINE_MAX)) begin
         overflow_in = 1'b1;
      end else begin
         if (line_length_ff == '0 && line_count_ff != LINE_COUNT_MAX) begin
            line_count_in = line_count_ff + 16'd1;
         end
         line_length_in     = line_length_ff + LINE_LEN_W'(1);
         prev_quote_in      = is_quote;
         result.line_number = line_count_in;
         result.is_header   = (line_count_in == header_line_number);

         if (line_count_in >= header_line_number) begin
            if (field_length_ff == '0) begin
               quoted_field_in = is_quote;
               quote_count_in  = QC_NONE;
            end
            if (!quoted_field_in) begin
               if (code_unit == UNIT_COMMA) do_end = 1'b1;
               else                         do_keep = 1'b1;
            end else begin
               if (is_quote) begin
                  quote_count_in = (quote_count_in == QC_ODD) ? QC_EVEN : QC_ODD;
               end
               if (code_unit == UNIT_COMMA && quote_count_in == QC_EVEN && prev_quote_ff) begin
                  do_end = 1'b1;
               end else if (!(is_quote && quote_count_in == QC_EVEN)) begin
                  do_keep = 1'b1;
               end
            end
         end

         if (do_end) begin
            has_result        = 1'b1;
            result.event_kind = EV_FIELD_END;
            if (field_index_ff < 8'(FIELD_CAP)) begin
               field_index_in = field_index_ff + 8'd1;
            end
            field_length_in = '0;
            quote_count_in  = QC_NONE;
            overflow_in     = 1'b0;
         end else if (do_keep) begin
            if (field_length_ff >= FIELD_LEN_W'(FIELD_MAX)) begin
               overflow_in = 1'b1;
            end else begin
               field_length_in   = field_length_ff + FIELD_LEN_W'(1);
               has_result        = 1'b1;
               result.event_kind = EV_UNIT;
               result.kept_unit  = code_unit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= '0;
         line_count_ff   <= '0;
         field_length_ff <= '0;
         field_index_ff  <= '0;
         quoted_field_ff <= 1'b0;
         quote_count_ff  <= QC_NONE;
         prev_quote_ff   <= 1'b0;
         overflow_ff     <= 1'b0;
      end else if (step) begin
         line_length_ff  <= line_length_in;
         line_count_ff   <= line_count_in;
         field_length_ff <= field_length_in;
         field_index_ff  <= field_index_in;
         quoted_field_ff <= quoted_field_in;
         quote_count_ff  <= quote_count_in;
         prev_quote_ff   <= prev_quote_in;
         overflow_ff     <= overflow_in;
      end
   end

endmodule

>>> rtl/csv_line_field_tokenizer_core.sv
// channel  | dir | handshake               | payload
// req      | in  | req_tvalid/req_tready   | tdata code_unit, tlast end_of_input
// rsp      | out | rsp_tvalid/rsp_tready   | tdata unit/field/line/flags, tuser kind
// csr      | in  | csr_valid/csr_ready     | csr_data header_line_number
//
// One code unit per cycle, sustained while the result side is ready.
// Stage one is the input register, stage two the result register; parser state
// updates when an item moves from one to the other.
// Synchronous active-high reset; header_line_number resets to 2.
// A stalled result holds the input stage, which then stalls the request side.
module csv_line_field_tokenizer_core
   import cft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] code_unit
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] kept_unit, [23:16] field_number,
                                    // [39:24] line_number, [40] is_header,
                                    // [41] truncated, [47:42] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        in_valid_ff;
   logic [15:0] in_unit_ff;
   logic        in_eoi_ff;
   logic [15:0] header_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        advance;
   logic        has_result;
   result_type  result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   cft_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .step               (advance),
      .code_unit          (in_unit_ff),
      .end_of_input       (in_eoi_ff),
      .header_line_number (header_ff),
      .has_result         (has_result),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         header_ff    <= HEADER_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= has_result;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            header_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
      end
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.event_kind;
   assign rsp_tdata  = {6'd0, out_ff.truncated, out_ff.is_header, out_ff.line_number,
                        out_ff.field_number, out_ff.kept_unit};

endmodule

>>> tb/testbench.sv
module testbench
   import cft_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 115;
   localparam int DRAIN_CYCLES   = 4;

   typedef struct {
      logic [15:0] unit;
      logic        eoi;
      bit          typed;
      bit          has;
      result_type  res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // [15:0] code_unit
   logic        req_tlast = 1'b0;       // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;              // [15:0] kept_unit, [23:16] field_number,
                                        // [39:24] line_number, [40] is_header,
                                        // [41] truncated, [47:42] zero
   logic [1:0]  rsp_tuser;              // [1:0] event_kind
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = 16'h0000;

   stim_row_type cur_row;
   stim_row_type script[$];
   result_type   pending[$];
   int           errors = 0;
   int           idle_run = 0;
   int           sent = 0;
   int           send_idle = 0;
   int           recv_stall = 0;

   // tokenizer mirror
   logic [15:0]     hdr_line;
   logic [15:0]     line_cnt;
   int              line_len;
   int              fld_len;
   logic [7:0]      fld_idx;
   bit              in_quotes;
   quote_count_type qstate;
   bit              last_quote;
   bit              dropped;

   csv_line_field_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall);
   end

   function automatic result_type make_event(event_kind_type kind, logic [15:0] u);
      result_type r;
      r.event_kind   = kind;
      r.kept_unit    = (kind == EV_UNIT) ? u : 16'h0000;
      r.field_number = fld_idx;
      r.line_number  = line_cnt;
      r.is_header    = (line_cnt == hdr_line);
      r.truncated    = dropped;
      return r;
   endfunction

   function automatic void start_line();
      line_len   = 0;
      fld_len    = 0;
      fld_idx    = 8'd0;
      in_quotes  = 1'b0;
      qstate     = QC_NONE;
      last_quote = 1'b0;
      dropped    = 1'b0;
   endfunction

   task automatic tokenize_unit(input logic [15:0] u, input logic eoi,
                                output bit has, output result_type r);
      bit is_q;
      bit prev_q;
      is_q   = (u == UNIT_QUOTE);
      prev_q = last_quote;
      has    = 1'b0;
      r      = '0;
      if (eoi || u == UNIT_LF || u == UNIT_CR) begin
         if (line_len > 0 && line_cnt >= hdr_line) begin
            r   = make_event(fld_len > 0 ? EV_LINE_FIELD : EV_LINE_EMPTY, 16'h0000);
            has = 1'b1;
         end
         start_line();
         if (eoi) line_cnt = 16'd0;
      end else if (line_len >= LINE_MAX) begin
         dropped = 1'b1;
      end else begin
         if (line_len == 0 && line_cnt != LINE_COUNT_MAX) line_cnt++;
         line_len++;
         last_quote = is_q;
         if (line_cnt >= hdr_line) begin
            if (fld_len == 0) begin
               in_quotes = is_q;
               qstate    = QC_NONE;
            end
            if (in_quotes && is_q) qstate = (qstate == QC_ODD) ? QC_EVEN : QC_ODD;
            if (u == UNIT_COMMA && (!in_quotes || (qstate == QC_EVEN && prev_q))) begin
               r   = make_event(EV_FIELD_END, 16'h0000);
               has = 1'b1;
               if (fld_idx < FIELD_CAP) fld_idx++;
               fld_len = 0;
               qstate  = QC_NONE;
               dropped = 1'b0;
            end else if (!(in_quotes && is_q && qstate == QC_EVEN)) begin
               if (fld_len >= FIELD_MAX) begin
                  dropped = 1'b1;
               end else begin
                  fld_len++;
                  r   = make_event(EV_UNIT, u);
                  has = 1'b1;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      bit         has;
      bit         moved;
      result_type nxt;
      result_type want;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            hdr_line = csr_data;
            moved    = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            tokenize_unit(req_tdata, req_tlast, has, nxt);
            if (cur_row.typed) begin
               has = cur_row.has;
               nxt = cur_row.res;
            end
            if (has) pending.insert(pending.size(), nxt);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (pending.size() == 0) begin
               $error("unexpected result: event_kind %0d", rsp_tuser);
               errors++;
            end else begin
               want = pending.pop_front();
               if (rsp_tuser !== want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d", want.event_kind, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[15:0] !== want.kept_unit) begin
                  $error("kept_unit: expected %0h, actual %0h",
                         want.kept_unit, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[23:16] !== want.field_number) begin
                  $error("field_number: expected %0d, actual %0d",
                         want.field_number, rsp_tdata[23:16]);
                  errors++;
               end
               if (rsp_tdata[39:24] !== want.line_number) begin
                  $error("line_number: expected %0d, actual %0d",
                         want.line_number, rsp_tdata[39:24]);
                  errors++;
               end
               if (rsp_tdata[40] !== want.is_header) begin
                  $error("is_header: expected %0d, actual %0d", want.is_header, rsp_tdata[40]);
                  errors++;
               end
               if (rsp_tdata[41] !== want.truncated) begin
                  $error("truncated: expected %0d, actual %0d", want.truncated, rsp_tdata[41]);
                  errors++;
               end
            end
         end
      end
      idle_run = moved ? 0 : idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic void add_row(logic [15:0] u, logic eoi);
      stim_row_type row;
      row.unit  = u;
      row.eoi   = eoi;
      row.typed = 1'b0;
      row.has   = 1'b0;
      row.res   = '0;
      script.insert(script.size(), row);
   endfunction

   function automatic void add_typed(logic [15:0] u, logic eoi, bit has,
                                     event_kind_type kind, logic [7:0] fld,
                                     logic [15:0] line, logic hdr);
      stim_row_type row;
      row.unit               = u;
      row.eoi                = eoi;
      row.typed              = 1'b1;
      row.has                = has;
      row.res.event_kind     = kind;
      row.res.kept_unit      = (kind == EV_UNIT) ? u : 16'h0000;
      row.res.field_number   = fld;
      row.res.line_number    = line;
      row.res.is_header      = hdr;
      row.res.truncated      = 1'b0;
      script.insert(script.size(), row);
   endfunction

   task automatic send_row(input stim_row_type row);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.unit;
      req_tlast  <= row.eoi;
      cur_row    <= row;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send(input logic [15:0] u, input logic eoi);
      stim_row_type row;
      row.unit  = u;
      row.eoi   = eoi;
      row.typed = 1'b0;
      row.has   = 1'b0;
      row.res   = '0;
      send_row(row);
   endtask

   function automatic logic [15:0] rand_text();
      if ($urandom_range(0, 99) < 80) return 16'h0061 + 16'($urandom_range(0, 25));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      send_idle  = (mode == 1) ? 46 : (mode == 3) ? 26 : 0;
      recv_stall = (mode == 2) ? 46 : (mode == 3) ? 26 : 0;
   endtask

   task automatic gen_line();
      int nf;
      int len;
      int r;
      if ($urandom_range(0, 99) < 10) send(16'($urandom_range(0, 65535)), 1'b0);
      if ($urandom_range(0, 99) < 8) send(UNIT_CR, 1'b0);
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) send(UNIT_COMMA, 1'b0);
         if ($urandom_range(0, 99) < 40) begin
            send(UNIT_QUOTE, 1'b0);
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(0, 99);
               if (r < 15) begin
                  send(UNIT_COMMA, 1'b0);
               end else if (r < 30) begin
                  send(UNIT_QUOTE, 1'b0);
                  send(UNIT_QUOTE, 1'b0);
               end else begin
                  send(rand_text(), 1'b0);
               end
            end
            if ($urandom_range(0, 99) < 85) send(UNIT_QUOTE, 1'b0);
         end else begin
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) send(rand_text(), 1'b0);
         end
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send(UNIT_LF, 1'b0);
      end else if (r < 75) begin
         send(UNIT_CR, 1'b0);
      end else if (r < 88) begin
         send(UNIT_CR, 1'b0);
         send(UNIT_LF, 1'b0);
      end else begin
         send(16'($urandom_range(0, 65535)), 1'b1);
      end
   endtask

   task automatic comma_run();
      int n;
      n = $urandom_range(256, 300);
      send(rand_text(), 1'b0);
      for (int k = 0; k < n; k++) send(UNIT_COMMA, 1'b0);
      send(rand_text(), 1'b0);
      send(UNIT_LF, 1'b0);
   endtask

   initial begin : stimulus
      logic [15:0] hdr_plan[8];
      hdr_plan = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd1, 16'd4, 16'd0, 16'd2};
      hdr_line = HEADER_RESET;
      line_cnt = 16'd0;
      start_line();
      cur_row = '{16'h0000, 1'b0, 1'b0, 1'b0, '0};

      // line 1 dropped, empty line skipped, line 2 is the header
      add_typed(16'h0061, 1'b0, 1'b0, EV_UNIT, 8'd0, 16'd0, 1'b0);
      add_typed(UNIT_LF, 1'b0, 1'b0, EV_UNIT, 8'd0, 16'd0, 1'b0);
      add_typed(UNIT_CR, 1'b0, 1'b0, EV_UNIT, 8'd0, 16'd0, 1'b0);
      add_typed(16'h0068, 1'b0, 1'b1, EV_UNIT, 8'd0, 16'd2, 1'b1);
      add_typed(UNIT_COMMA, 1'b0, 1'b1, EV_FIELD_END, 8'd0, 16'd2, 1'b1);
      add_typed(UNIT_COMMA, 1'b0, 1'b1, EV_FIELD_END, 8'd1, 16'd2, 1'b1);
      add_typed(UNIT_LF, 1'b0, 1'b1, EV_LINE_EMPTY, 8'd2, 16'd2, 1'b1);
      // quoted field with embedded comma and doubled quotes
      add_row(UNIT_QUOTE, 1'b0);
      add_row(UNIT_COMMA, 1'b0);
      add_row(UNIT_QUOTE, 1'b0);
      add_row(UNIT_QUOTE, 1'b0);
      add_row(UNIT_QUOTE, 1'b0);
      add_row(UNIT_COMMA, 1'b0);
      add_row(16'h0000, 1'b0);
      add_row(UNIT_QUOTE, 1'b0);
      add_row(UNIT_COMMA, 1'b0);
      add_row(UNIT_QUOTE, 1'b0);
      add_row(16'hFFFF, 1'b0);
      add_row(UNIT_CR, 1'b0);
      // end of input flushes the line and restarts numbering
      add_row(16'h007A, 1'b0);
      add_row(16'hAAAA, 1'b1);
      add_typed(16'h0071, 1'b0, 1'b0, EV_UNIT, 8'd0, 16'd0, 1'b0);
      add_typed(16'h5555, 1'b1, 1'b0, EV_UNIT, 8'd0, 16'd0, 1'b0);

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      set_idling(0);
      foreach (script[i]) send_row(script[i]);

      for (int p = 0; p < 8; p++) begin
         settle();
         write_header(hdr_plan[p]);
         set_idling(p % 4);
         if (p == 4) comma_run();
         sent = 0;
         while (sent < PHASE_ITEMS) gen_line();
      end

      settle();

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
